[hdl/swrl_pkg.sv]
// ----------------------------------------------------------------------------
// swrl_pkg: shared definitions for the sliding-window read rate limiter
// Field widths, register indexes, reset values and channel layouts.
// ----------------------------------------------------------------------------
`default_nettype none

package swrl_pkg;

  // Payload field widths.
  localparam int NOW_W   = 31;
  localparam int BYTES_W = 27;
  localparam int DELAY_W = 31;
  localparam int RATE_W  = 31;
  localparam int WIN_W   = 31;
  localparam int REL_W   = 32;

  // Channel widths, padded to whole bytes.
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 32;

  // Configuration port.
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 31;

  typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

  localparam cfg_addr_t CFG_IDX_ENABLE = 2'd0;
  localparam cfg_addr_t CFG_IDX_RATE   = 2'd1;
  localparam cfg_addr_t CFG_IDX_WINDOW = 2'd2;

  // Register reset values.
  localparam logic              ENABLE_RST = 1'b0;
  localparam logic [RATE_W-1:0] RATE_RST   = 31'd20971520;
  localparam logic [WIN_W-1:0]  WINDOW_RST = 31'd10000;

  // Delay saturation point.
  localparam logic [DELAY_W-1:0] DELAY_MAX = 31'h7FFF_FFFF;

  // Default ring depth.
  localparam int HISTORY_DEPTH_DEF = 100;

endpackage

`default_nettype wire

[hdl/swrl_ram.sv]
// ----------------------------------------------------------------------------
// swrl_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module swrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hdl/sliding_window_read_rate_limiter.sv]
// ----------------------------------------------------------------------------
// sliding_window_read_rate_limiter: delay computation for admitted reads
// Keeps a ring of recent reads (release time, size) in RAM, expires old
// entries, and returns the wait needed to keep throughput under the limit.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Transaction contents
// in_*      slave      now_ms [30:0], request_bytes [57:31]
// out_*     master     delay_ms [30:0]
// cfg_*     write only limit_enable (0), limit_bytes_per_sec (1), window_ms (2)
//
// An enabled request scans the n stored entries in RAM, then makes one or two passes of
// the shared restoring divider, whose dividend is DVD_W bits wide (44 at the default
// depth). Within the limit the second pass is skipped; a disabled request goes straight
// to its result. Reset is synchronous and empties the ring without clearing the RAM.
// A new request starts while the last delay waits; it then holds in ST_OUTP until the
// result frees.
//
`default_nettype none

module sliding_window_read_rate_limiter #(
  parameter int HISTORY_DEPTH = swrl_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Request stream.
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [swrl_pkg::IN_TDATA_W-1:0]     in_tdata,   // now_ms, request_bytes
  // Delay stream.
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic      [swrl_pkg::OUT_TDATA_W-1:0]    out_tdata,  // delay_ms
  // Configuration writes.
  input  wire logic                                cfg_we,
  input  wire logic [swrl_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire logic [swrl_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int NOW_W   = swrl_pkg::NOW_W;
  localparam int BYTES_W = swrl_pkg::BYTES_W;
  localparam int DELAY_W = swrl_pkg::DELAY_W;
  localparam int RATE_W  = swrl_pkg::RATE_W;
  localparam int WIN_W   = swrl_pkg::WIN_W;
  localparam int REL_W   = swrl_pkg::REL_W;

  localparam int IDX_W   = $clog2(HISTORY_DEPTH);
  localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
  // Up to HISTORY_DEPTH stored sizes plus the new one.
  localparam int TOT_W   = BYTES_W + CNT_W;
  // total * 1000 needs ten more bits.
  localparam int DVD_W   = TOT_W + 10;
  localparam int STEP_W  = $clog2(DVD_W);
  localparam int ENTRY_W = REL_W + BYTES_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ELAP,
    ST_DIV_RATE,
    ST_CMP,
    ST_DIV_NEED,
    ST_DLY,
    ST_WRITE,
    ST_OUTP
  } state_t;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_t              state_r,     state_nxt;
  logic                en_r,        en_nxt;
  logic [RATE_W-1:0]   rate_r,      rate_nxt;
  logic [WIN_W-1:0]    win_r,       win_nxt;

  logic [NOW_W-1:0]    now_r,       now_nxt;
  logic [BYTES_W-1:0]  size_r,      size_nxt;
  logic [REL_W-1:0]    begin_r,     begin_nxt;
  logic [TOT_W-1:0]    total_r,     total_nxt;

  logic [IDX_W-1:0]    oldest_r,    oldest_nxt;
  logic [CNT_W-1:0]    cnt_r,       cnt_nxt;
  logic [IDX_W-1:0]    scan_ptr_r,  scan_ptr_nxt;
  logic [CNT_W-1:0]    scan_left_r, scan_left_nxt;
  logic                rd_valid_r,  rd_valid_nxt;
  logic                expiring_r,  expiring_nxt;

  logic [NOW_W-1:0]    elapsed_r,   elapsed_nxt;
  logic [DVD_W-1:0]    t1000_r,     t1000_nxt;
  logic [DVD_W-1:0]    dvd_r,       dvd_nxt;
  logic [RATE_W-1:0]   dsr_r,       dsr_nxt;
  logic [RATE_W-1:0]   rem_r,       rem_nxt;
  logic [STEP_W-1:0]   step_r,      step_nxt;
  logic [DELAY_W-1:0]  delay_r,     delay_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [DELAY_W-1:0]  out_data_r,  out_data_nxt;

  // --------------------------------------------------------------------------
  // History RAM: {size, release time} per entry.
  // --------------------------------------------------------------------------
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;

  swrl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_ptr_r),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Datapath helpers
  // --------------------------------------------------------------------------
  logic [NOW_W-1:0]    in_now;
  logic [BYTES_W-1:0]  in_bytes;
  logic [REL_W-1:0]    rd_rel;
  logic [BYTES_W-1:0]  rd_bytes;
  logic [IDX_W-1:0]    oldest_inc;
  logic [IDX_W-1:0]    scan_ptr_inc;
  logic [REL_W-1:0]    win_begin;
  logic [RATE_W-1:0]   limit_eff;
  logic [RATE_W:0]     rem_sh;
  logic                div_fits;
  logic [DVD_W-1:0]    elapsed_ext;
  logic [DVD_W-1:0]    need_diff;
  logic                ring_full;
  logic [IDX_W-1:0]    old_adj;
  logic [CNT_W-1:0]    cnt_adj;
  logic [IDX_W:0]      wsum;

  assign in_now   = in_tdata[NOW_W-1:0];
  assign in_bytes = in_tdata[NOW_W+BYTES_W-1:NOW_W];
  assign rd_rel   = ram_rdata[REL_W-1:0];
  assign rd_bytes = ram_rdata[ENTRY_W-1:REL_W];

  assign oldest_inc   = (oldest_r == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : oldest_r + 1'b1;
  assign scan_ptr_inc = (scan_ptr_r == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : scan_ptr_r + 1'b1;

  // Start of the window before any survivor is found: tick minus window, floored at 0.
  assign win_begin = (in_now > win_r) ? {1'b0, in_now - win_r} : '0;

  // A zero limit acts as one byte per second.
  assign limit_eff = (rate_r == '0) ? RATE_W'(1) : rate_r;

  // One restoring division step: one quotient bit shifts into the dividend register.
  assign rem_sh   = {rem_r, dvd_r[DVD_W-1]};
  assign div_fits = (rem_sh >= {1'b0, dsr_r});

  assign elapsed_ext = DVD_W'(elapsed_r);
  assign need_diff   = dvd_r - elapsed_ext;

  // Ring slot for the new entry; a full ring first drops its oldest entry.
  assign ring_full = (cnt_r == CNT_W'(HISTORY_DEPTH));
  assign old_adj   = ring_full ? oldest_inc : oldest_r;
  assign cnt_adj   = ring_full ? CNT_W'(HISTORY_DEPTH - 1) : cnt_r;
  assign wsum      = (IDX_W+1)'(old_adj) + (IDX_W+1)'(cnt_adj);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    en_nxt        = en_r;
    rate_nxt      = rate_r;
    win_nxt       = win_r;
    now_nxt       = now_r;
    size_nxt      = size_r;
    begin_nxt     = begin_r;
    total_nxt     = total_r;
    oldest_nxt    = oldest_r;
    cnt_nxt       = cnt_r;
    scan_ptr_nxt  = scan_ptr_r;
    scan_left_nxt = scan_left_r;
    rd_valid_nxt  = 1'b0;
    expiring_nxt  = expiring_r;
    elapsed_nxt   = elapsed_r;
    t1000_nxt     = t1000_r;
    dvd_nxt       = dvd_r;
    dsr_nxt       = dsr_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    delay_nxt     = delay_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = (wsum >= (IDX_W+1)'(HISTORY_DEPTH))
                  ? IDX_W'(wsum - (IDX_W+1)'(HISTORY_DEPTH)) : IDX_W'(wsum);
    ram_wdata     = {size_r, {1'b0, now_r} + {1'b0, delay_r}};

    // Users issue configuration writes only while the block is idle (unchecked).
    if (cfg_we) begin
      case (cfg_addr)
        swrl_pkg::CFG_IDX_ENABLE: en_nxt   = cfg_wdata[0];
        swrl_pkg::CFG_IDX_RATE:   rate_nxt = cfg_wdata;
        swrl_pkg::CFG_IDX_WINDOW: win_nxt  = cfg_wdata;
        default: ;
      endcase
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          now_nxt  = in_now;
          size_nxt = in_bytes;
          if (!en_r) begin
            delay_nxt = '0;
            state_nxt = ST_OUTP;
          end else begin
            begin_nxt     = win_begin;
            total_nxt     = TOT_W'(in_bytes);
            scan_ptr_nxt  = oldest_r;
            scan_left_nxt = cnt_r;
            expiring_nxt  = 1'b1;
            state_nxt     = ST_SCAN;
          end
        end
      end

      // Reads are issued one per cycle; data returns in the following cycle.
      ST_SCAN: begin
        if (scan_left_r != '0) begin
          rd_valid_nxt  = 1'b1;
          scan_ptr_nxt  = scan_ptr_inc;
          scan_left_nxt = scan_left_r - 1'b1;
        end
        if (rd_valid_r) begin
          if (expiring_r && (rd_rel < begin_r)) begin
            oldest_nxt = oldest_inc;
            cnt_nxt    = cnt_r - 1'b1;
          end else begin
            if (expiring_r) begin
              begin_nxt = rd_rel;
            end
            expiring_nxt = 1'b0;
            total_nxt    = total_r + TOT_W'(rd_bytes);
          end
        end
        if ((scan_left_r == '0) && !rd_valid_r) begin
          state_nxt = ST_ELAP;
        end
      end

      ST_ELAP: begin
        elapsed_nxt = ({1'b0, now_r} > begin_r) ? now_r - begin_r[NOW_W-1:0] : NOW_W'(1);
        t1000_nxt   = DVD_W'({total_r, 10'b0}) - DVD_W'({total_r, 4'b0})
                    - DVD_W'({total_r, 3'b0});
        state_nxt   = ST_DIV_RATE;
      end

      ST_DIV_RATE, ST_DIV_NEED: begin
        if (step_r == '0 && state_r == ST_DIV_RATE && dsr_r != elapsed_r) begin
          // Never taken: divider is loaded below on entry.
          state_nxt = state_r;
        end
        rem_nxt  = div_fits ? RATE_W'(rem_sh - {1'b0, dsr_r}) : RATE_W'(rem_sh);
        dvd_nxt  = {dvd_r[DVD_W-2:0], div_fits};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(DVD_W - 1)) begin
          step_nxt  = '0;
          state_nxt = (state_r == ST_DIV_RATE) ? ST_CMP : ST_DLY;
        end
      end

      // Rate check: floor(total*1000 / elapsed) against the limit.
      ST_CMP: begin
        if (dvd_r > DVD_W'(limit_eff)) begin
          dvd_nxt   = t1000_r;
          dsr_nxt   = limit_eff;
          rem_nxt   = '0;
          step_nxt  = '0;
          state_nxt = ST_DIV_NEED;
        end else begin
          delay_nxt = '0;
          state_nxt = ST_WRITE;
        end
      end

      ST_DLY: begin
        if (dvd_r > elapsed_ext) begin
          delay_nxt = (need_diff > DVD_W'(swrl_pkg::DELAY_MAX))
                    ? swrl_pkg::DELAY_MAX : need_diff[DELAY_W-1:0];
        end else begin
          delay_nxt = '0;
        end
        state_nxt = ST_WRITE;
      end

      // The scan for the next request begins only after ST_OUTP and ST_IDLE,
      // so the written entry is settled before it can be read.
      ST_WRITE: begin
        ram_we     = 1'b1;
        oldest_nxt = old_adj;
        cnt_nxt    = cnt_adj + 1'b1;
        state_nxt  = ST_OUTP;
      end

      ST_OUTP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = delay_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // Load the divider for the rate division on the way out of ST_ELAP.
    if (state_r == ST_ELAP) begin
      dvd_nxt  = DVD_W'({total_r, 10'b0}) - DVD_W'({total_r, 4'b0})
               - DVD_W'({total_r, 3'b0});
      dsr_nxt  = elapsed_nxt;
      rem_nxt  = '0;
      step_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      en_r        <= swrl_pkg::ENABLE_RST;
      rate_r      <= swrl_pkg::RATE_RST;
      win_r       <= swrl_pkg::WINDOW_RST;
      oldest_r    <= '0;
      cnt_r       <= '0;
      scan_left_r <= '0;
      rd_valid_r  <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      en_r        <= en_nxt;
      rate_r      <= rate_nxt;
      win_r       <= win_nxt;
      oldest_r    <= oldest_nxt;
      cnt_r       <= cnt_nxt;
      scan_left_r <= scan_left_nxt;
      rd_valid_r  <= rd_valid_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
    now_r      <= now_nxt;
    size_r     <= size_nxt;
    begin_r    <= begin_nxt;
    total_r    <= total_nxt;
    scan_ptr_r <= scan_ptr_nxt;
    expiring_r <= expiring_nxt;
    elapsed_r  <= elapsed_nxt;
    t1000_r    <= t1000_nxt;
    dvd_r      <= dvd_nxt;
    dsr_r      <= dsr_nxt;
    rem_r      <= rem_nxt;
    delay_r    <= delay_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(swrl_pkg::OUT_TDATA_W - DELAY_W){1'b0}}, out_data_r};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(HISTORY_DEPTH))
    else $error("history count exceeds ring depth");

  a_write_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> (cnt_r != '0))
    else $error("ring empty after storing an entry");

  a_read_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_valid_r |-> ($past(state_r) == ST_SCAN))
    else $error("read data flagged outside the history scan");

  a_disabled_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !en_r) |=> ((delay_r == '0) && (state_r == ST_OUTP)))
    else $error("disabled limiter produced a nonzero delay");

endmodule

`default_nettype wire

[tb/swrl_delay_checker.sv]
// ----------------------------------------------------------------------------
// swrl_delay_checker: delay prediction and comparison for the rate limiter
// Watches the request, delay and register channels, keeps its own history
// ring and register copies, predicts each delay and compares it in order.
// ----------------------------------------------------------------------------

module swrl_delay_checker
  import swrl_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // now_ms, request_bytes
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // delay_ms
  input  logic                   cfg_we,
  input  cfg_addr_t              cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output int                     mismatches,
  output int                     pending,
  output int                     checked,
  output int                     saturated,
  output int                     evicted
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] MS_PER_SEC = 64'd1000;
  localparam int          RING_IDX_W = $clog2(HISTORY_DEPTH);

  logic               lim_enable;
  logic [RATE_W-1:0]  lim_rate;
  logic [WIN_W-1:0]   lim_window;
  logic [REL_W-1:0]   ring_release [HISTORY_DEPTH];
  logic [BYTES_W-1:0] ring_bytes [HISTORY_DEPTH];
  int unsigned        ring_head;
  int unsigned        ring_count;
  logic [DELAY_W-1:0] predicted_delays [$];

  function automatic int unsigned ring_step(input int unsigned i);
    return (i + 1 >= HISTORY_DEPTH) ? 0 : i + 1;
  endfunction

  // Returns zero when disabled; otherwise expires old reads, measures the windowed rate
  // including this read, logs the read at its release time and returns the delay it has to wait.
  function automatic logic [DELAY_W-1:0] admit_request(input logic [NOW_W-1:0] now,
                                                       input logic [BYTES_W-1:0] nbytes);
    logic [63:0] now64;
    logic [63:0] start;
    logic [63:0] total;
    logic [63:0] elapsed;
    logic [63:0] rate;
    logic [63:0] need;
    logic [63:0] delay;
    int unsigned idx;
    int unsigned k;
    int unsigned tail;
    if (!lim_enable) begin
      return '0;
    end
    now64 = {33'd0, now};
    start = (now64 > {33'd0, lim_window}) ? now64 - {33'd0, lim_window} : 64'd0;
    while (ring_count > 0 && {32'd0, ring_release[RING_IDX_W'(ring_head)]} < start) begin
      ring_head = ring_step(ring_head);
      ring_count--;
    end
    total = 64'd0;
    idx = ring_head;
    for (k = 0; k < ring_count; k++) begin
      total += {37'd0, ring_bytes[RING_IDX_W'(idx)]};
      idx = ring_step(idx);
    end
    if (ring_count > 0) begin
      start = {32'd0, ring_release[RING_IDX_W'(ring_head)]};
    end
    total += {37'd0, nbytes};
    elapsed = (now64 > start) ? now64 - start : 64'd1;
    rate = (lim_rate == '0) ? 64'd1 : {33'd0, lim_rate};
    delay = 64'd0;
    if ((total * MS_PER_SEC) / elapsed > rate) begin
      need = (total * MS_PER_SEC) / rate;
      delay = (need > elapsed) ? need - elapsed : 64'd0;
      if (delay > {33'd0, DELAY_MAX}) begin
        delay = {33'd0, DELAY_MAX};
        saturated++;
      end
    end
    if (ring_count >= HISTORY_DEPTH) begin
      ring_head = ring_step(ring_head);
      ring_count = HISTORY_DEPTH - 1;
      evicted++;
    end
    tail = ring_head + ring_count;
    if (tail >= HISTORY_DEPTH) begin
      tail -= HISTORY_DEPTH;
    end
    ring_release[RING_IDX_W'(tail)] = now64[31:0] + delay[31:0];
    ring_bytes[RING_IDX_W'(tail)] = nbytes;
    ring_count++;
    return delay[DELAY_W-1:0];
  endfunction

  always @(posedge clk) begin : monitor
    logic [DELAY_W-1:0] want;
    if (!rst_n) begin
      lim_enable = ENABLE_RST;
      lim_rate   = RATE_RST;
      lim_window = WINDOW_RST;
      ring_head  = 0;
      ring_count = 0;
      predicted_delays.delete();
      mismatches = 0;
      pending    = 0;
      checked    = 0;
      saturated  = 0;
      evicted    = 0;
    end else begin
      // A delay always leaves after its request is accepted, never in the same cycle, so the
      // oldest prediction is retired before a new one is added.
      if (out_tvalid && out_tready) begin
        if (predicted_delays.size() == 0) begin
          mismatches++;
          $error("delay_ms transaction with no request waiting: actual %0d",
                 out_tdata[DELAY_W-1:0]);
        end else begin
          want = predicted_delays.pop_front();
          checked++;
          if (out_tdata[DELAY_W-1:0] !== want) begin
            mismatches++;
            $error("delay_ms mismatch: expected %0d, actual %0d",
                   want, out_tdata[DELAY_W-1:0]);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        predicted_delays.push_back(admit_request(in_tdata[NOW_W-1:0],
                                                 in_tdata[NOW_W +: BYTES_W]));
      end
      if (cfg_we) begin
        case (cfg_addr)
          CFG_IDX_ENABLE: lim_enable = cfg_wdata[0];
          CFG_IDX_RATE:   lim_rate   = cfg_wdata[RATE_W-1:0];
          CFG_IDX_WINDOW: lim_window = cfg_wdata[WIN_W-1:0];
          default: ;
        endcase
      end
      pending = predicted_delays.size();
    end
  end

endmodule

[tb/sliding_window_read_rate_limiter_tb.sv]
// ----------------------------------------------------------------------------
// sliding_window_read_rate_limiter_tb: top level of the rate limiter bench
// Drives read requests and register writes, applies idling and back-pressure,
// and reports the verdict from the delay checker running beside the block.
// ----------------------------------------------------------------------------

module sliding_window_read_rate_limiter_tb;

  import swrl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Field maxima, but BYTES_MAX is 2**26; used by the directed part and the register settings.
  localparam logic [NOW_W-1:0]   NOW_MAX   = 31'h7FFF_FFFF;
  localparam logic [BYTES_W-1:0] BYTES_MAX = 27'd67108864;
  localparam logic [RATE_W-1:0]  RATE_MAX  = 31'h7FFF_FFFF;
  localparam logic [WIN_W-1:0]   WIN_MAX   = 31'h7FFF_FFFF;

  // The watchdog limit exceeds the slowest request and the longest receiver
  // hold-off, so a quiet stretch that reaches it means a hang.
  localparam int HOLD_OFF_CYCLES = 1000;
  localparam int WATCHDOG_LIMIT  = 10000;
  localparam int DRAIN_CYCLES    = 300;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // now_ms, request_bytes
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // delay_ms
  logic                   cfg_we     = 1'b0;
  cfg_addr_t              cfg_addr   = CFG_IDX_ENABLE;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  int mismatches;
  int pending;
  int checked;
  int saturated;
  int evicted;

  // Traffic shaping. The sender percentage is only used by the stimulus
  // process; the receiver percentage and the hold-off requests cross to the
  // receiver process, so they change with nonblocking assignments.
  int          send_idle_pct = 0;
  int          rx_stall_pct  = 0;
  int          holds_asked   = 0;
  int          holds_taken   = 0;
  int          hold_left     = 0;
  int          idle_cycles   = 0;
  int          requests_sent = 0;
  int          settings_applied = 0;
  logic [NOW_W-1:0] tick = '0;

  sliding_window_read_rate_limiter DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  swrl_delay_checker u_delay_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked),
    .saturated  (saturated),
    .evicted    (evicted)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver decides out_tready once per cycle on the falling edge. A
  // hold-off request from the stimulus keeps it low for a long stretch that
  // this process counts down itself, while the sender keeps offering
  // requests so the block fills up and pushes back on its input.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (holds_taken != holds_asked) begin
      holds_taken <= holds_asked;
      hold_left   <= HOLD_OFF_CYCLES;
      out_tready  <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Any accepted transaction on either channel restarts the count.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("sliding_window_read_rate_limiter test failed");
      $finish;
    end
  end

  // Offers one request starting at a falling edge, with a random number of
  // idle cycles first, and returns on the falling edge after the transaction
  // is accepted. Valid stays high into the next request unless it idles.
  task automatic send_request(input logic [NOW_W-1:0] now, input logic [BYTES_W-1:0] nbytes);
    int gap;
    gap = 0;
    while (gap < 200 && $urandom_range(0, 99) < send_idle_pct) begin
      gap++;
    end
    repeat (gap) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - NOW_W - BYTES_W){1'b0}}, nbytes, now};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    requests_sent++;
  endtask

  // If any delay is outstanding, stops offering and waits until every predicted delay has come back.
  task automatic drain_delays();
    if (pending != 0) begin
      in_tvalid <= 1'b0;
      while (pending != 0) @(negedge clk);
    end
  endtask

  task automatic write_reg(input cfg_addr_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(negedge clk);
  endtask

  // Registers change only while the block is idle: the task waits for every delay
  // to return and then lets the block settle so nothing is left in flight.
  task automatic apply_settings(input logic en, input logic [RATE_W-1:0] rate,
                                input logic [WIN_W-1:0] win);
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    write_reg(CFG_IDX_ENABLE, {{(CFG_DATA_W - 1){1'b0}}, en});
    write_reg(CFG_IDX_RATE, rate);
    write_reg(CFG_IDX_WINDOW, win);
    cfg_we <= 1'b0;
    @(negedge clk);
    settings_applied++;
  endtask

  // Most requests follow a rising millisecond tick, the way a reader polls
  // the clock before each block read; a few carry an arbitrary tick, which
  // breaks the ordering of the history. Sizes mix small, medium and huge.
  task automatic make_request(output logic [NOW_W-1:0] now, output logic [BYTES_W-1:0] nbytes);
    logic [31:0] step;
    logic [31:0] next_tick;
    if ($urandom_range(0, 99) < 8) begin
      now = NOW_W'($urandom());
    end else begin
      case ($urandom_range(0, 3))
        0:       step = 32'd0;
        1:       step = $urandom_range(1, 20);
        2:       step = $urandom_range(1, 400);
        default: step = $urandom_range(0, 30000);
      endcase
      next_tick = {1'b0, tick} + step;
      tick = (next_tick > {1'b0, NOW_MAX}) ? NOW_MAX : next_tick[NOW_W-1:0];
      now = tick;
    end
    case ($urandom_range(0, 7))
      0, 1, 2: nbytes = BYTES_W'($urandom_range(0, 4096));
      3, 4:    nbytes = BYTES_W'($urandom_range(0, 1 << 20));
      5, 6:    nbytes = BYTES_W'($urandom_range(0, BYTES_MAX));
      default: nbytes = $urandom_range(0, 1) ? BYTES_MAX : '0;
    endcase
  endtask

  // One register setting with random traffic. The hold-off is requested a
  // few requests in; pause_at, when in range, makes the sender wait until
  // every delay has come back before going on.
  task automatic run_phase(input logic en, input logic [RATE_W-1:0] rate,
                           input logic [WIN_W-1:0] win, input int count,
                           input int send_pct, input int rx_pct,
                           input bit hold_off, input int pause_at);
    logic [NOW_W-1:0]   now;
    logic [BYTES_W-1:0] nbytes;
    int i;
    apply_settings(en, rate, win);
    send_idle_pct = send_pct;
    rx_stall_pct <= rx_pct;
    for (i = 0; i < count; i++) begin
      if (hold_off && i == 5) begin
        holds_asked <= holds_asked + 1;
      end
      if (i == pause_at) begin
        drain_delays();
      end
      make_request(now, nbytes);
      send_request(now, nbytes);
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. Right after reset the limiter is disabled, so these
    // two get no delay and must leave the history empty.
    send_request('0, '0);
    send_request(NOW_MAX, BYTES_MAX);

    // Default rate and window. A request at tick zero sees a window start
    // that is not before the tick, so the elapsed time is forced to one.
    apply_settings(1'b1, RATE_RST, WINDOW_RST);
    send_request('0, '0);
    send_request('0, BYTES_MAX);
    send_request(31'd5, 27'd1000);
    send_request(31'd4000, 27'd500000);
    // Far enough ahead that every logged read falls out of the window.
    send_request(31'd25000, 27'd4096);

    // A zero rate register acts as one byte per second, and the delay for
    // a large read then overflows and saturates.
    apply_settings(1'b1, '0, WINDOW_RST);
    send_request(31'd25001, BYTES_MAX);
    send_request(31'd25002, 27'd1);

    // Slowest legal rate with a zero-length window.
    apply_settings(1'b1, 31'd1, '0);
    send_request(31'd30000, '0);
    send_request(31'd30000, 27'd7);
    send_request(31'd30001, BYTES_MAX);

    // Fastest rate with the widest window: nothing ever expires.
    apply_settings(1'b1, RATE_MAX, WIN_MAX);
    send_request(NOW_MAX, BYTES_MAX);
    send_request(31'd100, 27'd1);
    send_request(NOW_MAX, '0);

    apply_settings(1'b0, RATE_RST, WINDOW_RST);
    send_request(31'd12345, 27'd999);

    // Random part, one register setting per phase, cycling through the
    // idling patterns: none, sender idle, receiver stalling, and both.
    tick = 31'd40000;
    run_phase(1'b1, RATE_RST, WINDOW_RST, 250, 0, 0, 1'b0, 120);
    run_phase(1'b1, 31'd1, 31'd10000, 120, 82, 0, 1'b0, -1);
    run_phase(1'b1, RATE_MAX, WIN_MAX, 150, 0, 82, 1'b0, -1);
    run_phase(1'b1, RATE_W'($urandom_range(1000000, 100000000)), '0, 120, 21, 21, 1'b0, -1);
    run_phase(1'b0, RATE_W'($urandom_range(1, RATE_MAX)), WIN_W'($urandom()), 100, 82, 0,
              1'b0, -1);
    run_phase(1'b1, RATE_W'($urandom_range(50000000, 400000000)), 31'd1000, 250, 0, 82,
              1'b1, -1);
    run_phase(1'b1, RATE_W'($urandom_range(1, RATE_MAX)), WIN_W'($urandom_range(0, 20000)),
              200, 21, 21, 1'b0, -1);
    // Ticks close to the top of their range, clamping at the maximum.
    tick = NOW_MAX - 31'd3000;
    run_phase(1'b1, RATE_RST, WINDOW_RST, 240, 0, 0, 1'b0, -1);

    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d read requests under %0d register settings, limited and unlimited,",
             requests_sent, settings_applied);
    $display("with idle, stalled and held-off traffic; %0d delays checked, %0d saturated,",
             checked, saturated);
    $display("%0d evictions.", evicted);
    if (mismatches == 0 && pending == 0) begin
      $display("sliding_window_read_rate_limiter test passed");
    end else begin
      $display("sliding_window_read_rate_limiter test failed");
    end
    $finish;
  end

endmodule
